[design/bwst_pkg.sv]
// bwst_pkg: shared types and codes for the bone weight slot table
// request codes, status codes, slot geometry and q1.15 scaling constants
// no dependencies
`timescale 1ns / 1ps

package bwst_pkg;

   localparam int SLOTS      = 4;
   localparam int SLOT_IDX_W = $clog2(SLOTS);
   localparam int BONE_W     = 8;
   localparam int INDEX_W    = 9;
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = WEIGHT_W + SLOT_IDX_W;
   // q1.15: 1.0 is 2^15, so a quotient needs one bit above the 15 fraction bits
   localparam int FRAC_W     = 15;
   localparam int DIV_STEPS  = FRAC_W + 1;
   localparam int REM_W      = SUM_W + 1;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
   localparam int STATUS_W   = 3;

   localparam logic [SUM_W-1:0] ONE_Q15 = SUM_W'(1) << FRAC_W;

   typedef logic [1:0]          req_type_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam req_type_type REQ_ADD   = 2'd0;
   localparam req_type_type REQ_NORM  = 2'd1;
   localparam req_type_type REQ_CLEAR = 2'd2;

   localparam status_type ST_UPDATED    = 3'd0;
   localparam status_type ST_REPLACED   = 3'd1;
   localparam status_type ST_REJECTED   = 3'd2;
   localparam status_type ST_DROPPED    = 3'd3;
   localparam status_type ST_NORMALIZED = 3'd4;
   localparam status_type ST_NORM_SKIP  = 3'd5;
   localparam status_type ST_CLEARED    = 3'd6;

endpackage

[design/bwst_div.sv]
// bwst_div: radix-2 restoring divider, one quotient bit per cycle
// computes floor(weight * 2^15 / sum) for weight <= sum; uses bwst_pkg
`timescale 1ns / 1ps

module bwst_div
   import bwst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [WEIGHT_W-1:0] dividend,
   input  logic [SUM_W-1:0]    divisor,
   output logic                done,
   output logic [WEIGHT_W-1:0] quotient
);

   logic                 busy_ff,  busy_in;
   logic                 first_ff, first_in;
   logic                 done_ff,  done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [REM_W-1:0]     rem_ff,   rem_in;
   logic [SUM_W-1:0]     divisor_ff, divisor_in;
   logic [WEIGHT_W-1:0]  quot_ff,  quot_in;

   logic [REM_W-1:0] trial;
   logic [REM_W-1:0] diff;
   logic             fits;

   // first step compares the weight itself, later steps the doubled remainder
   always_comb begin
      trial = first_ff ? rem_ff : {rem_ff[REM_W-2:0], 1'b0};
      diff  = trial - {1'b0, divisor_ff};
      fits  = trial >= {1'b0, divisor_ff};
   end

   always_comb begin
      busy_in    = busy_ff;
      first_in   = first_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      quot_in    = quot_ff;
      if (start) begin
         busy_in    = 1'b1;
         first_in   = 1'b1;
         count_in   = DIV_CNT_W'(DIV_STEPS);
         rem_in     = REM_W'(dividend);
         divisor_in = divisor;
         quot_in    = '0;
      end else if (busy_ff) begin
         first_in = 1'b0;
         rem_in   = fits ? diff : trial;
         quot_in  = {quot_ff[WEIGHT_W-2:0], fits};
         count_in = count_ff - DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         first_ff <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         first_ff <= first_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      quot_ff    <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !first_ff) |-> (rem_ff < REM_W'(divisor_ff)))
      else $error("divider remainder not below divisor");

endmodule

[design/bone_weight_slot_table_top.sv]
// Bone weight slot table: four (bone, weight) slots for one vertex, updated by add, normalize
// and clear requests. Every accepted request returns one beat with a status and all four slots
// as they stand after the request. Add, clear and unused requests go from idle straight to the
// done state, which loads their result beat once the output register is free. Normalize first
// sums the weights of the four slots, then, if the sum is not zero, runs four divisions by that
// sum on one shared restoring divider at one quotient bit per cycle. The request side takes a new
// beat once the previous result sits in the output register, even while it waits on rsp_ready.
// depends on bwst_pkg and bwst_div
`timescale 1ns / 1ps

module bone_weight_slot_table_top
   import bwst_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_type,
   input  logic signed [INDEX_W-1:0] req_bone_index,
   input  logic [WEIGHT_W-1:0] req_bone_weight,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [BONE_W-1:0]   rsp_slot0_bone,
   output logic [BONE_W-1:0]   rsp_slot1_bone,
   output logic [BONE_W-1:0]   rsp_slot2_bone,
   output logic [BONE_W-1:0]   rsp_slot3_bone,
   output logic [WEIGHT_W-1:0] rsp_slot0_weight,
   output logic [WEIGHT_W-1:0] rsp_slot1_weight,
   output logic [WEIGHT_W-1:0] rsp_slot2_weight,
   output logic [WEIGHT_W-1:0] rsp_slot3_weight
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SUM      = 3'd1;
   localparam logic [2:0] S_DIV_GO   = 3'd2;
   localparam logic [2:0] S_DIV_WAIT = 3'd3;
   localparam logic [2:0] S_DONE     = 3'd4;

   localparam logic [SLOT_IDX_W-1:0] LAST_SLOT = SLOT_IDX_W'(SLOTS - 1);

   logic [2:0]            state_ff, state_in;
   logic [BONE_W-1:0]     bone_ff   [SLOTS];
   logic [BONE_W-1:0]     bone_in   [SLOTS];
   logic [WEIGHT_W-1:0]   weight_ff [SLOTS];
   logic [WEIGHT_W-1:0]   weight_in [SLOTS];
   logic [SLOT_IDX_W-1:0] idx_ff, idx_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   status_type            status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_load;
   status_type            rsp_status_ff;
   logic [BONE_W-1:0]     rsp_bone_ff   [SLOTS];
   logic [WEIGHT_W-1:0]   rsp_weight_ff [SLOTS];

   logic                  match_hit, room_hit;
   logic [SLOT_IDX_W-1:0] match_idx, room_idx;
   logic                  div_start, div_done;
   logic [WEIGHT_W-1:0]   div_quot;

   // first slot holding the bone, and first slot lighter than the new weight
   always_comb begin
      match_hit = 1'b0;
      room_hit  = 1'b0;
      match_idx = '0;
      room_idx  = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (bone_ff[i] == req_bone_index[BONE_W-1:0]) begin
            match_hit = 1'b1;
            match_idx = SLOT_IDX_W'(i);
         end
         if (weight_ff[i] < req_bone_weight) begin
            room_hit = 1'b1;
            room_idx = SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      bone_in      = bone_ff;
      weight_in    = weight_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      status_in    = status_ff;
      div_start    = 1'b0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DONE;
               unique case (req_type)
                  REQ_ADD: begin
                     priority if (req_bone_index[INDEX_W-1] || req_bone_weight == '0) begin
                        status_in = ST_REJECTED;
                     end else if (match_hit) begin
                        weight_in[match_idx] = req_bone_weight;
                        status_in            = ST_UPDATED;
                     end else if (room_hit) begin
                        weight_in[room_idx] = req_bone_weight;
                        bone_in[room_idx]   = req_bone_index[BONE_W-1:0];
                        status_in           = ST_REPLACED;
                     end else begin
                        status_in = ST_DROPPED;
                     end
                  end
                  REQ_NORM: begin
                     sum_in   = '0;
                     idx_in   = '0;
                     state_in = S_SUM;
                  end
                  REQ_CLEAR: begin
                     for (int i = 0; i < SLOTS; i++) begin
                        bone_in[i]   = '0;
                        weight_in[i] = '0;
                     end
                     status_in = ST_CLEARED;
                  end
                  default: begin
                     status_in = ST_REJECTED;
                  end
               endcase
            end
         end
         S_SUM: begin
            sum_in = sum_ff + SUM_W'(weight_ff[idx_ff]);
            idx_in = idx_ff + SLOT_IDX_W'(1);
            if (idx_ff == LAST_SLOT) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            if (sum_ff == '0) begin
               status_in = ST_NORM_SKIP;
               state_in  = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               weight_in[idx_ff] = div_quot;
               idx_in            = idx_ff + SLOT_IDX_W'(1);
               if (idx_ff == LAST_SLOT) begin
                  status_in = ST_NORMALIZED;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_DIV_GO;
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            bone_ff[i]   <= '0;
            weight_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         bone_ff      <= bone_in;
         weight_ff    <= weight_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      status_ff <= status_in;
      if (rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_bone_ff   <= bone_ff;
         rsp_weight_ff <= weight_ff;
      end
   end

   bwst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (weight_ff[idx_ff]),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot0_bone   = rsp_bone_ff[0];
   assign rsp_slot1_bone   = rsp_bone_ff[1];
   assign rsp_slot2_bone   = rsp_bone_ff[2];
   assign rsp_slot3_bone   = rsp_bone_ff[3];
   assign rsp_slot0_weight = rsp_weight_ff[0];
   assign rsp_slot1_weight = rsp_weight_ff[1];
   assign rsp_slot2_weight = rsp_weight_ff[2];
   assign rsp_slot3_weight = rsp_weight_ff[3];

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV_WAIT))
      else $error("divider finished outside the wait state");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("result beat not presented after load");

   a_norm_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_NORMALIZED) |->
         ((SUM_W'(rsp_weight_ff[0]) + SUM_W'(rsp_weight_ff[1]) +
           SUM_W'(rsp_weight_ff[2]) + SUM_W'(rsp_weight_ff[3])) <= ONE_Q15))
      else $error("normalized weights sum above one");

endmodule

[verif/bone_weight_slot_table_top_test.sv]
// testbench for bone_weight_slot_table_top: directed and random add, normalize and clear beats
// with an in-bench slot table predictor, random idling on both channels and a long response hold
// depends on bwst_pkg and the bone_weight_slot_table_top rtl
`timescale 1ns / 1ps

module bone_weight_slot_table_top_test;
   import bwst_pkg::*;

   localparam int           CLOCK_PERIOD = 12;
   localparam int           CYCLE_LIMIT  = 1000000;
   localparam int           DRAIN_CYCLES = 120;
   localparam int           HOLD_CYCLES  = 400;
   localparam req_type_type REQ_UNUSED   = 2'd3;

   typedef struct packed {
      status_type                     status;
      logic [SLOTS-1:0][BONE_W-1:0]   bones;
      logic [SLOTS-1:0][WEIGHT_W-1:0] weights;
   } slot_report_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [1:0]                 req_type = REQ_ADD;
   logic signed [INDEX_W-1:0]  req_bone_index = '0;
   logic [WEIGHT_W-1:0]        req_bone_weight = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [STATUS_W-1:0]        rsp_status;
   logic [BONE_W-1:0]          rsp_slot0_bone, rsp_slot1_bone, rsp_slot2_bone, rsp_slot3_bone;
   logic [WEIGHT_W-1:0]        rsp_slot0_weight, rsp_slot1_weight;
   logic [WEIGHT_W-1:0]        rsp_slot2_weight, rsp_slot3_weight;

   // predicted slot table
   logic [BONE_W-1:0]          table_bones   [SLOTS];
   logic [WEIGHT_W-1:0]        table_weights [SLOTS];
   slot_report_type            expected_reports [$];

   int                         mismatch_count = 0;
   int                         cycle_count    = 0;
   int                         send_idle_pct  = 0;
   int                         recv_stall_pct = 0;
   int                         hold_requests  = 0;

   bone_weight_slot_table_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_type         (req_type),
      .req_bone_index   (req_bone_index),
      .req_bone_weight  (req_bone_weight),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot0_bone   (rsp_slot0_bone),
      .rsp_slot1_bone   (rsp_slot1_bone),
      .rsp_slot2_bone   (rsp_slot2_bone),
      .rsp_slot3_bone   (rsp_slot3_bone),
      .rsp_slot0_weight (rsp_slot0_weight),
      .rsp_slot1_weight (rsp_slot1_weight),
      .rsp_slot2_weight (rsp_slot2_weight),
      .rsp_slot3_weight (rsp_slot3_weight)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   function automatic slot_report_type apply_request(input req_type_type kind,
                                                     input logic signed [INDEX_W-1:0] idx,
                                                     input logic [WEIGHT_W-1:0] w);
      slot_report_type  rep;
      logic [SUM_W-1:0] total;
      logic [63:0]      quotient;
      bit               placed;
      int               i;
      rep.status = ST_REJECTED;
      case (kind)
         REQ_ADD: begin
            if (!idx[INDEX_W-1] && w != '0) begin
               placed = 1'b0;
               // a matching index wins over any weight comparison
               for (i = 0; i < SLOTS; i++) begin
                  if (!placed && table_bones[i] == idx[BONE_W-1:0]) begin
                     table_weights[i] = w;
                     rep.status = ST_UPDATED;
                     placed = 1'b1;
                  end
               end
               for (i = 0; i < SLOTS; i++) begin
                  if (!placed && table_weights[i] < w) begin
                     table_weights[i] = w;
                     table_bones[i] = idx[BONE_W-1:0];
                     rep.status = ST_REPLACED;
                     placed = 1'b1;
                  end
               end
               if (!placed) rep.status = ST_DROPPED;
            end
         end
         REQ_NORM: begin
            total = '0;
            for (i = 0; i < SLOTS; i++) total = total + SUM_W'(table_weights[i]);
            if (total == '0) begin
               rep.status = ST_NORM_SKIP;
            end else begin
               for (i = 0; i < SLOTS; i++) begin
                  quotient = (64'(table_weights[i]) << FRAC_W) / 64'(total);
                  table_weights[i] = quotient[WEIGHT_W-1:0];
               end
               rep.status = ST_NORMALIZED;
            end
         end
         REQ_CLEAR: begin
            for (i = 0; i < SLOTS; i++) begin
               table_bones[i] = '0;
               table_weights[i] = '0;
            end
            rep.status = ST_CLEARED;
         end
         default: ;
      endcase
      for (i = 0; i < SLOTS; i++) begin
         rep.bones[i] = table_bones[i];
         rep.weights[i] = table_weights[i];
      end
      return rep;
   endfunction

   // called at a rising edge; returns at the edge that takes the beat, or after the idle gap
   task automatic send_request(input req_type_type kind,
                               input logic signed [INDEX_W-1:0] idx,
                               input logic [WEIGHT_W-1:0] w);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_bone_index  <= idx;
      req_bone_weight <= w;
      do @(negedge clock); while (req_ready !== 1'b1);
      @(posedge clock);
      expected_reports.insert(expected_reports.size(), apply_request(kind, idx, w));
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic send_add(input int idx, input int w);
      send_request(REQ_ADD, INDEX_W'(idx), WEIGHT_W'(w));
   endtask

   task automatic test_directed();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      send_request(REQ_NORM, '1, '1);        // zero sum right after reset
      send_add(0, 1);                         // index 0 matches a cleared slot
      send_add(-1, 100);
      send_add(-256, 100);
      send_add(5, 0);
      send_add(255, 65535);
      send_add(0, 300);
      send_add(10, 200);
      send_add(11, 150);
      send_add(12, 100);                      // no lighter slot, dropped
      send_add(12, 65535);
      send_add(10, 1);
      send_request(REQ_UNUSED, '1, '1);
      send_request(REQ_NORM, '0, '0);
      send_request(REQ_NORM, '0, '0);
      send_request(REQ_CLEAR, '1, '1);
      send_add(1, 65535);
      send_add(2, 65535);
      send_add(3, 65535);
      send_add(0, 65535);
      send_add(9, 65535);                     // full table of max weights
      send_request(REQ_NORM, '0, '0);         // largest possible sum
      send_add(200, 8193);
      send_request(REQ_NORM, '0, '0);
      send_request(REQ_CLEAR, '0, '0);
   endtask

   // vertex-like sequences: optional clear, a run of adds with some noise, then an optional normalize
   task automatic test_random(input int item_count, input int idle_pct, input int stall_pct);
      int                        sent;
      int                        roll;
      logic signed [INDEX_W-1:0] idx;
      logic [WEIGHT_W-1:0]       w;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < item_count) begin
         if ($urandom_range(99) < 30) begin
            send_request(REQ_CLEAR, INDEX_W'($urandom), WEIGHT_W'($urandom));
            sent++;
         end
         repeat ($urandom_range(2, 7)) begin
            idx = $urandom_range(1) ? INDEX_W'($urandom_range(7)) : INDEX_W'($urandom_range(255));
            roll = $urandom_range(99);
            if (roll < 40)      w = WEIGHT_W'($urandom_range(1, 65535));
            else if (roll < 75) w = WEIGHT_W'($urandom_range(1, 512));
            else                w = WEIGHT_W'(65535 - $urandom_range(0, 64));
            roll = $urandom_range(99);
            if (roll < 4) begin
               send_request(REQ_ADD, INDEX_W'($urandom_range(256, 511)), w);
            end else if (roll < 8) begin
               send_request(REQ_ADD, idx, '0);
            end else if (roll < 11) begin
               send_request(REQ_UNUSED, INDEX_W'($urandom), WEIGHT_W'($urandom));
            end else begin
               send_request(REQ_ADD, idx, w);
            end
            sent++;
         end
         if ($urandom_range(99) < 70) begin
            send_request(REQ_NORM, INDEX_W'($urandom), WEIGHT_W'($urandom));
            sent++;
         end
      end
   endtask

   // response side holds off while the request side keeps offering beats
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (40) begin
         if ($urandom_range(99) < 20)
            send_request(REQ_NORM, '0, '0);
         else
            send_add($urandom_range(15), $urandom_range(1, 65535));
      end
   endtask

   initial begin : rsp_drain
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // the handshake inputs are stable at the falling edge, so a beat seen here is taken next edge
   initial begin : rsp_check
      slot_report_type got;
      slot_report_type want;
      int              i;
      forever begin
         @(negedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            got.status     = rsp_status;
            got.bones[0]   = rsp_slot0_bone;
            got.bones[1]   = rsp_slot1_bone;
            got.bones[2]   = rsp_slot2_bone;
            got.bones[3]   = rsp_slot3_bone;
            got.weights[0] = rsp_slot0_weight;
            got.weights[1] = rsp_slot1_weight;
            got.weights[2] = rsp_slot2_weight;
            got.weights[3] = rsp_slot3_weight;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected beat: expected none, got status %0d", $time, got.status);
            end else begin
               want = expected_reports.pop_front();
               if (got.status !== want.status) begin
                  mismatch_count++;
                  $display("%0t: status mismatch: expected %0d, got %0d",
                           $time, want.status, got.status);
               end
               for (i = 0; i < SLOTS; i++) begin
                  if (got.bones[i] !== want.bones[i]) begin
                     mismatch_count++;
                     $display("%0t: slot%0d bone mismatch: expected %0d, got %0d",
                              $time, i, want.bones[i], got.bones[i]);
                  end
                  if (got.weights[i] !== want.weights[i]) begin
                     mismatch_count++;
                     $display("%0t: slot%0d weight mismatch: expected %0d, got %0d",
                              $time, i, want.weights[i], got.weights[i]);
                  end
               end
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   initial begin : test_sequence
      int i;
      for (i = 0; i < SLOTS; i++) begin
         table_bones[i] = '0;
         table_weights[i] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(380, 0, 0);
      test_random(380, 47, 0);
      test_random(380, 0, 47);
      test_random(380, 17, 17);
      test_backpressure();
      req_valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

[filelist.f]
design/bwst_pkg.sv
design/bwst_div.sv
design/bone_weight_slot_table_top.sv
verif/bone_weight_slot_table_top_test.sv
